/* rtl/core/rrs_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// rrs_pkg : shared types, codes and helpers for row_reduce_select
// Mode and type codes, register indexes, the start value of a row and the
// order-preserving compare key.
// ============================================================================
package rrs_pkg;

   localparam int DATA_W = 64;
   localparam int MODE_W = 3;
   localparam int ETYPE_W = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 3;

   // Operation codes
   localparam logic [MODE_W-1:0] MODE_SUM    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_MAX    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MIN    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ARGMAX = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ARGMIN = 3'd4;

   // Element type codes
   localparam logic [ETYPE_W-1:0] TYPE_I32 = 2'd0;
   localparam logic [ETYPE_W-1:0] TYPE_I64 = 2'd1;
   localparam logic [ETYPE_W-1:0] TYPE_F32 = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OP_MODE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEM_TYPE = 1'd1;

   // Constants
   localparam logic [DATA_W-1:0] SIGN64      = 64'h8000_0000_0000_0000;
   localparam logic [DATA_W-1:0] I64_MAX     = 64'h7fff_ffff_ffff_ffff;
   localparam logic [DATA_W-1:0] I32_MIN     = 64'h0000_0000_8000_0000;
   localparam logic [DATA_W-1:0] I32_MAX     = 64'h0000_0000_7fff_ffff;
   localparam logic [DATA_W-1:0] F32_POS_INF = 64'h0000_0000_7f80_0000;
   localparam logic [DATA_W-1:0] F32_NEG_INF = 64'h0000_0000_ff80_0000;
   localparam logic [31:0]       F32_NEG_ZERO = 32'h8000_0000;
   localparam logic [31:0]       F32_EXP_MASK = 32'h7f80_0000;

   typedef struct packed {
      logic [MODE_W-1:0]  op_mode;
      logic [ETYPE_W-1:0] elem_type;
   } cfg_type;

   function automatic logic pair_ok(input cfg_type cfg);
      logic ok;
      case (cfg.op_mode)
         MODE_SUM:    ok = (cfg.elem_type == TYPE_I32) || (cfg.elem_type == TYPE_I64);
         MODE_MAX,
         MODE_MIN:    ok = (cfg.elem_type == TYPE_I32) || (cfg.elem_type == TYPE_I64) ||
                           (cfg.elem_type == TYPE_F32);
         MODE_ARGMAX,
         MODE_ARGMIN: ok = (cfg.elem_type == TYPE_F32);
         default:     ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic is_arg(input cfg_type cfg);
      return (cfg.op_mode == MODE_ARGMAX) || (cfg.op_mode == MODE_ARGMIN);
   endfunction

   // Identity of the mode: zero for sum, type minimum for max, type maximum for min
   function automatic logic [DATA_W-1:0] start_value(input cfg_type cfg);
      logic [DATA_W-1:0] v;
      logic want_max;
      logic want_min;
      want_max = (cfg.op_mode == MODE_MAX) || (cfg.op_mode == MODE_ARGMAX);
      want_min = (cfg.op_mode == MODE_MIN) || (cfg.op_mode == MODE_ARGMIN);
      v = '0;
      if (want_max) begin
         if (cfg.elem_type == TYPE_I32) v = I32_MIN;
         else if (cfg.elem_type == TYPE_I64) v = SIGN64;
         else v = F32_NEG_INF;
      end else if (want_min) begin
         if (cfg.elem_type == TYPE_I32) v = I32_MAX;
         else if (cfg.elem_type == TYPE_I64) v = I64_MAX;
         else v = F32_POS_INF;
      end
      return v;
   endfunction

   // Unsigned key whose order follows the signed or float order of the value
   function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] bits,
                                                   input logic [ETYPE_W-1:0] etype);
      logic [31:0] b;
      logic [DATA_W-1:0] k;
      b = bits[31:0];
      if (etype == TYPE_I64) begin
         k = bits ^ SIGN64;
      end else if (etype == TYPE_I32) begin
         k = {~b[31], {31{b[31]}}, b};
      end else begin
         // fold -0 onto +0
         if (b == F32_NEG_ZERO) b = '0;
         if (b[31]) k = {32'd0, ~b};
         else k = {32'd0, b | F32_NEG_ZERO};
      end
      return k;
   endfunction

   function automatic logic is_nan(input logic [DATA_W-1:0] bits,
                                   input logic [ETYPE_W-1:0] etype);
      return (etype == TYPE_F32) && ((bits[31:0] & F32_EXP_MASK) == F32_EXP_MASK) &&
             (bits[22:0] != 23'd0);
   endfunction

endpackage

/* rtl/core/rrs_update.sv */
`timescale 1ns / 1ps
// ============================================================================
// rrs_update : one-element row update
// Folds one element into the running row state (add, or key compare and
// select) and forms the result word for a row that closes on this element.
// ============================================================================
module rrs_update #(
   parameter int INDEX_BITS = 32
) (
   input  rrs_pkg::cfg_type               cfg,
   input  logic [rrs_pkg::DATA_W-1:0]     element_bits,
   input  logic [rrs_pkg::DATA_W-1:0]     running_value,
   input  logic [INDEX_BITS-1:0]          best_index,
   input  logic [INDEX_BITS-1:0]          element_count,
   output logic [rrs_pkg::DATA_W-1:0]     next_value,
   output logic [INDEX_BITS-1:0]          next_best,
   output logic [rrs_pkg::DATA_W-1:0]     result_bits,
   output logic                           unsupported
);

   logic                          ok;
   logic                          want_max;
   logic [rrs_pkg::DATA_W-1:0]    x;
   logic [rrs_pkg::DATA_W-1:0]    sum;
   logic [rrs_pkg::DATA_W-1:0]    key_x;
   logic [rrs_pkg::DATA_W-1:0]    key_r;
   logic                          better;

   assign ok = rrs_pkg::pair_ok(cfg);
   assign want_max = (cfg.op_mode == rrs_pkg::MODE_MAX) ||
                     (cfg.op_mode == rrs_pkg::MODE_ARGMAX);

   // Drop the upper half for 32-bit types
   assign x = (cfg.elem_type == rrs_pkg::TYPE_I64) ? element_bits
                                                  : {32'd0, element_bits[31:0]};

   // Wrapping sum, kept to 32 bits for int32
   always_comb begin
      sum = running_value + x;
      if (cfg.elem_type == rrs_pkg::TYPE_I32) sum = {32'd0, sum[31:0]};
   end

   // Compare through the order key; NaN never wins
   assign key_x = rrs_pkg::order_key(x, cfg.elem_type);
   assign key_r = rrs_pkg::order_key(running_value, cfg.elem_type);
   assign better = !rrs_pkg::is_nan(x, cfg.elem_type) &&
                   (want_max ? (key_x > key_r) : (key_x < key_r));

   // Select the next row state
   always_comb begin
      next_value = running_value;
      next_best  = best_index;
      if (ok) begin
         if (cfg.op_mode == rrs_pkg::MODE_SUM) begin
            next_value = sum;
         end else if (better) begin
            next_value = x;
            next_best  = element_count;
         end
      end
   end

   // Form the result word
   always_comb begin
      if (!ok) result_bits = '0;
      else if (rrs_pkg::is_arg(cfg))
         result_bits = {{(rrs_pkg::DATA_W-INDEX_BITS){1'b0}}, next_best};
      else result_bits = next_value;
   end

   assign unsupported = !ok;

endmodule

/* rtl/core/row_reduce_select.sv */
`timescale 1ns / 1ps
// ============================================================================
// row_reduce_select : streaming row reduction with one result per row
// Takes one element per cycle with no bubbles and no gap between rows while
// the output register is free. An element is registered at the input, then
// folded into the row state, and the result of a row is registered at the
// output. The throughput of one element per cycle is set by the row state
// loop: one 64-bit add, or one key compare and select, per cycle. Elements
// keep flowing while a result waits at the output; only a closing element
// waits for the output register to free up. A register write restarts the
// row at the identity of the new setting and must be made while idle.
// ============================================================================
module row_reduce_select #(
   parameter int INDEX_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // element channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rrs_pkg::DATA_W-1:0]        req_element_bits,
   input  logic                              req_last_of_row,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rrs_pkg::DATA_W-1:0]        rsp_result_bits,
   output logic                              rsp_unsupported,
   // register write port
   input  logic                              csr_write_en,
   input  logic [rrs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rrs_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   rrs_pkg::cfg_type               cfg_ff, cfg_in;

   logic                           in_valid_ff, in_valid_in;
   logic [rrs_pkg::DATA_W-1:0]     in_bits_ff;
   logic                           in_last_ff;

   logic [rrs_pkg::DATA_W-1:0]     value_ff, value_in;
   logic [INDEX_BITS-1:0]          best_ff, best_in;
   logic [INDEX_BITS-1:0]          count_ff, count_in;

   logic                           out_valid_ff, out_valid_in;
   logic [rrs_pkg::DATA_W-1:0]     out_bits_ff;
   logic                           out_unsup_ff;

   logic                           req_fire;
   logic                           out_free;
   logic                           advance;
   logic                           row_end;

   logic [rrs_pkg::DATA_W-1:0]     upd_value;
   logic [INDEX_BITS-1:0]          upd_best;
   logic [rrs_pkg::DATA_W-1:0]     upd_result;
   logic                           upd_unsup;

   // Handshake
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign row_end   = advance && in_last_ff;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   rrs_update #(
      .INDEX_BITS (INDEX_BITS)
   ) u_update (
      .cfg           (cfg_ff),
      .element_bits  (in_bits_ff),
      .running_value (value_ff),
      .best_index    (best_ff),
      .element_count (count_ff),
      .next_value    (upd_value),
      .next_best     (upd_best),
      .result_bits   (upd_result),
      .unsupported   (upd_unsup)
   );

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            rrs_pkg::CSR_OP_MODE:   cfg_in.op_mode   = csr_write_data;
            rrs_pkg::CSR_ELEM_TYPE: cfg_in.elem_type =
                                       csr_write_data[rrs_pkg::ETYPE_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   // Row state: restart on a register write or a closed row, else fold
   always_comb begin
      value_in = value_ff;
      best_in  = best_ff;
      count_in = count_ff;
      if (csr_write_en) begin
         value_in = rrs_pkg::start_value(cfg_in);
         best_in  = '0;
         count_in = '0;
      end else if (row_end) begin
         value_in = rrs_pkg::start_value(cfg_ff);
         best_in  = '0;
         count_in = '0;
      end else if (advance) begin
         value_in = upd_value;
         best_in  = upd_best;
         count_in = count_ff + 1'b1;
      end
   end

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = row_end || (out_valid_ff && !rsp_ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         value_ff     <= '0;
         best_ff      <= '0;
         count_ff     <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         value_ff     <= value_in;
         best_ff      <= best_in;
         count_ff     <= count_in;
      end
   end

   // Payload registers: input loads on accept, output on row end, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_bits_ff <= req_element_bits;
         in_last_ff <= req_last_of_row;
      end
      if (row_end) begin
         out_bits_ff  <= upd_result;
         out_unsup_ff <= upd_unsup;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_bits = out_bits_ff;
   assign rsp_unsupported = out_unsup_ff;

   // Checks
   a_unsup_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_unsup_ff |-> out_bits_ff == '0)
      else $error("unsupported result carries nonzero bits");

   a_mid_row_flows: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_last_ff |-> advance)
      else $error("mid-row element stalled");

   a_row_restart: assert property (@(posedge clock) disable iff (reset)
      row_end && !csr_write_en |=> count_ff == '0 && best_ff == '0)
      else $error("row state not restarted after row end");

   a_arg_upper_zero: assert property (@(posedge clock) disable iff (reset)
      row_end && !upd_unsup && rrs_pkg::is_arg(cfg_ff) |=>
      out_bits_ff[rrs_pkg::DATA_W-1:INDEX_BITS] == '0)
      else $error("arg result wider than index");

endmodule

/* tb/sv/tb_row_reduce_select.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_row_reduce_select : self-checking testbench for row_reduce_select
// A queue-fed driver streams row elements and a monitor checks every row
// result against an in-bench row reducer that tracks the same settings.
// Directed rows cover wrap-around, extremes, float corner values, ties,
// unsupported settings and a row abandoned by a register write. A long
// random part follows, with random gaps on both sides and one long receiver
// hold-off that backs the block up.
// ============================================================================
module tb_row_reduce_select;

   localparam int          IDX_W          = 32;
   localparam int          TOTAL_ITEMS    = 1275;
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          SETTLE_CYCLES  = 6;
   localparam logic [2:0]  MODE_UNUSED_TOP = 3'd7;
   localparam logic [1:0]  TYPE_UNUSED     = 2'd3;
   localparam logic [31:0] F32_ONE  = 32'h3f80_0000;
   localparam logic [31:0] F32_TWO  = 32'h4000_0000;
   localparam logic [31:0] F32_QNAN = 32'h7fc0_0000;

   typedef struct {
      logic [rrs_pkg::DATA_W-1:0] bits;
      logic                       last;
      int unsigned                gap;
   } pending_elem_type;

   typedef struct {
      logic [rrs_pkg::DATA_W-1:0] result_bits;
      logic                       unsupported;
   } row_result_type;

   // DUT connections, driven inputs known from time zero
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [rrs_pkg::DATA_W-1:0]     req_element_bits = '0;
   logic                           req_last_of_row = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [rrs_pkg::DATA_W-1:0]     rsp_result_bits;
   logic                           rsp_unsupported;
   logic                           csr_write_en = 1'b0;
   logic [rrs_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [rrs_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   // Row reducer state and its copy of the settings
   logic [rrs_pkg::MODE_W-1:0]  cfg_mode;
   logic [rrs_pkg::ETYPE_W-1:0] cfg_etype;
   logic [rrs_pkg::DATA_W-1:0]  row_acc;
   logic [IDX_W-1:0]            row_best_idx;
   logic [IDX_W-1:0]            row_elem_cnt;

   pending_elem_type elem_q[$];
   row_result_type   row_results_q[$];

   int          items_queued  = 0;
   int          fail_count    = 0;
   int          quiet_cycles  = 0;
   bit          gaps_on       = 1'b0;
   bit          pressure_arm  = 1'b0;
   bit          pressure_done = 1'b0;
   int unsigned gap_left      = 0;
   bit          gap_loaded    = 1'b0;
   int unsigned resp_wait     = 0;
   int unsigned hold_left     = 0;
   pending_elem_type head_elem;
   row_result_type   want;

   row_reduce_select #(
      .INDEX_BITS(IDX_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_element_bits(req_element_bits),
      .req_last_of_row (req_last_of_row),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_bits (rsp_result_bits),
      .rsp_unsupported (rsp_unsupported),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Row reducer
   // ------------------------------------------------------------------
   function automatic logic combo_supported(input logic [rrs_pkg::MODE_W-1:0] m,
                                            input logic [rrs_pkg::ETYPE_W-1:0] t);
      if (t == TYPE_UNUSED) return 1'b0;
      case (m)
         rrs_pkg::MODE_SUM:                          return t != rrs_pkg::TYPE_F32;
         rrs_pkg::MODE_MAX, rrs_pkg::MODE_MIN:       return 1'b1;
         rrs_pkg::MODE_ARGMAX, rrs_pkg::MODE_ARGMIN: return t == rrs_pkg::TYPE_F32;
         default:                                    return 1'b0;
      endcase
   endfunction

   function automatic logic [rrs_pkg::DATA_W-1:0] row_identity(
      input logic [rrs_pkg::MODE_W-1:0] m,
      input logic [rrs_pkg::ETYPE_W-1:0] t);
      if (m == rrs_pkg::MODE_MAX || m == rrs_pkg::MODE_ARGMAX) begin
         if (t == rrs_pkg::TYPE_I32) return {32'd0, 32'h8000_0000};
         if (t == rrs_pkg::TYPE_I64) return {1'b1, 63'd0};
         return {32'd0, 32'hff80_0000};
      end
      if (m == rrs_pkg::MODE_MIN || m == rrs_pkg::MODE_ARGMIN) begin
         if (t == rrs_pkg::TYPE_I32) return {32'd0, 32'h7fff_ffff};
         if (t == rrs_pkg::TYPE_I64) return {1'b0, {63{1'b1}}};
         return {32'd0, 32'h7f80_0000};
      end
      return '0;
   endfunction

   // Unsigned key ordered like the signed or float value; -0 folds onto +0
   function automatic logic [rrs_pkg::DATA_W-1:0] sort_key(
      input logic [rrs_pkg::DATA_W-1:0] v,
      input logic [rrs_pkg::ETYPE_W-1:0] t);
      logic [31:0] lo;
      lo = v[31:0];
      if (t == rrs_pkg::TYPE_I64) return {~v[63], v[62:0]};
      if (t == rrs_pkg::TYPE_I32) return {~lo[31], {31{lo[31]}}, lo};
      if (lo == 32'h8000_0000) lo = 32'd0;
      if (lo[31]) return {32'd0, ~lo};
      return {32'd0, 1'b1, lo[30:0]};
   endfunction

   function automatic logic f32_is_nan(input logic [31:0] v);
      return (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
   endfunction

   function automatic void restart_row();
      row_acc      = row_identity(cfg_mode, cfg_etype);
      row_best_idx = '0;
      row_elem_cnt = '0;
   endfunction

   // Fold one accepted element in; a closing element queues the row result
   function automatic void fold_element(input logic [rrs_pkg::DATA_W-1:0] raw,
                                        input logic last);
      logic [rrs_pkg::DATA_W-1:0] x;
      logic                       ok;
      logic                       want_max;
      logic                       better;
      row_result_type             r;
      ok = combo_supported(cfg_mode, cfg_etype);
      x  = (cfg_etype == rrs_pkg::TYPE_I64) ? raw : {32'd0, raw[31:0]};
      if (ok) begin
         if (cfg_mode == rrs_pkg::MODE_SUM) begin
            row_acc = row_acc + x;
            if (cfg_etype == rrs_pkg::TYPE_I32) row_acc[63:32] = 32'd0;
         end else if (!(cfg_etype == rrs_pkg::TYPE_F32 && f32_is_nan(x[31:0]))) begin
            want_max = (cfg_mode == rrs_pkg::MODE_MAX) || (cfg_mode == rrs_pkg::MODE_ARGMAX);
            better = want_max ? (sort_key(x, cfg_etype) > sort_key(row_acc, cfg_etype))
                              : (sort_key(x, cfg_etype) < sort_key(row_acc, cfg_etype));
            if (better) begin
               row_acc      = x;
               row_best_idx = row_elem_cnt;
            end
         end
      end
      row_elem_cnt = row_elem_cnt + 1'b1;
      if (last) begin
         if (!ok) r.result_bits = '0;
         else if (cfg_mode == rrs_pkg::MODE_ARGMAX || cfg_mode == rrs_pkg::MODE_ARGMIN)
            r.result_bits = {{(rrs_pkg::DATA_W-IDX_W){1'b0}}, row_best_idx};
         else r.result_bits = row_acc;
         r.unsupported = !ok;
         row_results_q.insert(row_results_q.size(), r);
         restart_row();
      end
   endfunction

   // ------------------------------------------------------------------
   // Element driver: hold each transaction until accepted, then gap
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         gap_left   = 0;
         gap_loaded = 1'b0;
      end else begin
         if (req_valid && req_ready) fold_element(req_element_bits, req_last_of_row);
         if (!req_valid || req_ready) begin
            if (elem_q.size() != 0 && !gap_loaded) begin
               gap_left   = elem_q[0].gap;
               gap_loaded = 1'b1;
            end
            if (elem_q.size() != 0 && gap_left == 0) begin
               head_elem = elem_q.pop_front();
               gap_loaded = 1'b0;
               req_valid        <= 1'b1;
               req_element_bits <= head_elem.bits;
               req_last_of_row  <= head_elem.last;
            end else begin
               req_valid <= 1'b0;
               if (gap_left != 0) gap_left = gap_left - 1;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor: check against the oldest expected row result
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (row_results_q.size() == 0) begin
               $display("%0t: unexpected result: actual bits %h unsupported %b",
                        $time, rsp_result_bits, rsp_unsupported);
               fail_count = fail_count + 1;
            end else begin
               want = row_results_q.pop_front();
               if (want.result_bits !== rsp_result_bits) begin
                  $display("%0t: result_bits mismatch: expected %h actual %h",
                           $time, want.result_bits, rsp_result_bits);
                  fail_count = fail_count + 1;
               end
               if (want.unsupported !== rsp_unsupported) begin
                  $display("%0t: unsupported mismatch: expected %b actual %b",
                           $time, want.unsupported, rsp_unsupported);
                  fail_count = fail_count + 1;
               end
            end
            resp_wait = gaps_on ? $urandom_range(0, 3) : 0;
         end
         // one long hold-off so the block backs up into its input
         if (pressure_arm && !pressure_done) begin
            hold_left     = HOLD_CYCLES;
            pressure_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (resp_wait != 0) begin
            resp_wait = resp_wait - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long without any transaction ends the run
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic [rrs_pkg::DATA_W-1:0] rand_element(
      input logic [rrs_pkg::ETYPE_W-1:0] t);
      logic [rrs_pkg::DATA_W-1:0] v;
      logic [31:0]                r;
      int                         kind;
      v    = {$urandom, $urandom};
      r    = $urandom;
      kind = $urandom_range(0, 11);
      case (kind)
         0: v[31:0] = r[0] ? rrs_pkg::F32_POS_INF[31:0] : rrs_pkg::F32_NEG_INF[31:0];
         1: v[31:0] = {r[31], 8'hff, r[22:1], 1'b1};
         2: v[31:0] = r[0] ? 32'd0 : rrs_pkg::F32_NEG_ZERO;
         3: v[31:0] = r[0] ? rrs_pkg::I32_MIN[31:0] : rrs_pkg::I32_MAX[31:0];
         4: v = r[0] ? rrs_pkg::SIGN64 : rrs_pkg::I64_MAX;
         5: v = r[0] ? '1 : {61'd0, r[3:1]};
         6, 7: begin
            v[31:0] = $urandom_range(0, 8) - 4;
            if (t == rrs_pkg::TYPE_I64) v[63:32] = {32{v[31]}};
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic push_elem(input logic [rrs_pkg::DATA_W-1:0] bits, input logic last);
      pending_elem_type e;
      e.bits = bits;
      e.last = last;
      e.gap  = gaps_on ? $urandom_range(0, 3) : 0;
      elem_q.insert(elem_q.size(), e);
      items_queued = items_queued + 1;
   endtask

   task automatic queue_row(input int len, input logic [rrs_pkg::ETYPE_W-1:0] t);
      for (int i = 0; i < len; i++) push_elem(rand_element(t), i == len - 1);
   endtask

   // Wait until every element is taken and every result is back, then settle
   task automatic wait_drained();
      do @(negedge clock);
      while (elem_q.size() != 0 || req_valid || row_results_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [rrs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rrs_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
      if (idx == rrs_pkg::CSR_OP_MODE) cfg_mode = data;
      else cfg_etype = data[rrs_pkg::ETYPE_W-1:0];
      restart_row();
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      int                             rows;
      int                             len;
      logic [rrs_pkg::MODE_W-1:0]     mode;
      logic [rrs_pkg::ETYPE_W-1:0]    etype;
      logic [rrs_pkg::CSR_DATA_W-1:0] etype_word;

      cfg_mode  = rrs_pkg::MODE_SUM;
      cfg_etype = rrs_pkg::TYPE_I32;
      restart_row();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sum int32 from reset: wrap past the top; upper bits ignored
      push_elem(rrs_pkg::I32_MAX, 1'b0);
      push_elem(64'd1, 1'b1);
      push_elem({32'hffff_ffff, 32'd5}, 1'b1);
      wait_drained();
      // sum int64 wrap
      write_reg(rrs_pkg::CSR_ELEM_TYPE, {1'b0, rrs_pkg::TYPE_I64});
      push_elem('1, 1'b0);
      push_elem(rrs_pkg::SIGN64, 1'b1);
      wait_drained();
      // max int32: a row equal to the start value, then a negative element
      write_reg(rrs_pkg::CSR_OP_MODE, rrs_pkg::MODE_MAX);
      write_reg(rrs_pkg::CSR_ELEM_TYPE, {1'b0, rrs_pkg::TYPE_I32});
      push_elem(rrs_pkg::I32_MIN, 1'b1);
      push_elem(64'd5, 1'b0);
      push_elem(64'hffff_ffff, 1'b1);
      wait_drained();
      // min int64 at both extremes
      write_reg(rrs_pkg::CSR_OP_MODE, rrs_pkg::MODE_MIN);
      write_reg(rrs_pkg::CSR_ELEM_TYPE, {1'b0, rrs_pkg::TYPE_I64});
      push_elem(rrs_pkg::I64_MAX, 1'b0);
      push_elem(rrs_pkg::SIGN64, 1'b1);
      wait_drained();
      // max float: NaN only gives the start value; -0 against 1.0
      write_reg(rrs_pkg::CSR_OP_MODE, rrs_pkg::MODE_MAX);
      write_reg(rrs_pkg::CSR_ELEM_TYPE, {1'b0, rrs_pkg::TYPE_F32});
      push_elem({32'd0, F32_QNAN}, 1'b1);
      push_elem({32'd0, rrs_pkg::F32_NEG_ZERO}, 1'b0);
      push_elem({32'd0, F32_ONE}, 1'b1);
      wait_drained();
      // argmax with ties: first occurrence wins, NaN never does
      write_reg(rrs_pkg::CSR_OP_MODE, rrs_pkg::MODE_ARGMAX);
      push_elem({32'd0, F32_ONE}, 1'b0);
      push_elem({32'd0, F32_ONE}, 1'b0);
      push_elem({32'd0, F32_TWO}, 1'b0);
      push_elem({32'd0, F32_QNAN}, 1'b0);
      push_elem({32'd0, F32_TWO}, 1'b1);
      wait_drained();
      // argmin over a row with no winner
      write_reg(rrs_pkg::CSR_OP_MODE, rrs_pkg::MODE_ARGMIN);
      push_elem({32'd0, F32_QNAN}, 1'b0);
      push_elem({32'hdead_beef, F32_QNAN}, 1'b1);
      wait_drained();
      // min float over both infinities
      write_reg(rrs_pkg::CSR_OP_MODE, rrs_pkg::MODE_MIN);
      push_elem(rrs_pkg::F32_NEG_INF, 1'b0);
      push_elem(rrs_pkg::F32_POS_INF, 1'b1);
      wait_drained();
      // unsupported pair, then selectors without meaning
      write_reg(rrs_pkg::CSR_OP_MODE, rrs_pkg::MODE_ARGMAX);
      write_reg(rrs_pkg::CSR_ELEM_TYPE, {1'b0, rrs_pkg::TYPE_I32});
      push_elem(rand_element(rrs_pkg::TYPE_I32), 1'b1);
      wait_drained();
      write_reg(rrs_pkg::CSR_OP_MODE, MODE_UNUSED_TOP);
      write_reg(rrs_pkg::CSR_ELEM_TYPE, {1'b0, TYPE_UNUSED});
      push_elem(rand_element(TYPE_UNUSED), 1'b1);
      wait_drained();
      // a register write drops the row in progress
      write_reg(rrs_pkg::CSR_OP_MODE, rrs_pkg::MODE_MAX);
      write_reg(rrs_pkg::CSR_ELEM_TYPE, {1'b0, rrs_pkg::TYPE_I64});
      push_elem(64'd100, 1'b0);
      wait_drained();
      write_reg(rrs_pkg::CSR_ELEM_TYPE, {1'b0, rrs_pkg::TYPE_I64});
      push_elem(64'd5, 1'b1);
      wait_drained();

      // back-pressure: short rows offered flat out while results are held
      write_reg(rrs_pkg::CSR_OP_MODE, rrs_pkg::MODE_SUM);
      write_reg(rrs_pkg::CSR_ELEM_TYPE, {1'b0, rrs_pkg::TYPE_I64});
      gaps_on      = 1'b0;
      pressure_arm = 1'b1;
      for (int i = 0; i < 40; i++) queue_row($urandom_range(1, 2), rrs_pkg::TYPE_I64);

      // random phases, each under a fresh setting
      while (items_queued < TOTAL_ITEMS) begin
         wait_drained();
         if ($urandom_range(0, 7) == 0) begin
            mode  = 3'($urandom_range(0, 7));
            etype = 2'($urandom_range(0, 3));
         end else begin
            mode = 3'($urandom_range(0, 4));
            case (mode)
               rrs_pkg::MODE_SUM:    etype = 2'($urandom_range(0, 1));
               rrs_pkg::MODE_ARGMAX,
               rrs_pkg::MODE_ARGMIN: etype = rrs_pkg::TYPE_F32;
               default:              etype = 2'($urandom_range(0, 2));
            endcase
         end
         etype_word    = {1'b0, etype};
         etype_word[2] = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 1) != 0) begin
            write_reg(rrs_pkg::CSR_OP_MODE, mode);
            write_reg(rrs_pkg::CSR_ELEM_TYPE, etype_word);
         end else begin
            write_reg(rrs_pkg::CSR_ELEM_TYPE, etype_word);
            write_reg(rrs_pkg::CSR_OP_MODE, mode);
         end
         gaps_on = ($urandom_range(0, 3) != 0);
         rows    = $urandom_range(3, 12);
         for (int i = 0; i < rows; i++) begin
            len = ($urandom_range(0, 6) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            queue_row(len, etype);
         end
         // leave a row open now and then for the next write to drop
         if ($urandom_range(0, 4) == 0)
            for (int i = $urandom_range(1, 3); i > 0; i--) push_elem(rand_element(etype), 1'b0);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && row_results_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/rrs_pkg.sv
rtl/core/rrs_update.sv
rtl/core/row_reduce_select.sv
tb/sv/tb_row_reduce_select.sv
